/* hdl/bfc_pkg.sv */
package bfc_pkg;

	localparam int LEVEL_W    = 16;
	localparam int TIME_W     = 16;
	localparam int KIND_W     = 2;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = LEVEL_W + TIME_W;
	localparam int CNT_W      = $clog2(PROD_W);

	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DIM     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DIMMING = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DIMMED  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL   = 2'd2;

	localparam logic [TIME_W-1:0]  FADE_TIME_RST     = 16'd5000;
	localparam logic [TIME_W-1:0]  STEP_INTERVAL_RST = 16'd100;
	localparam logic [LEVEL_W-1:0] FLOOR_LEVEL_RST   = 16'd0;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LEVEL_W-1:0] present_level;
	} bfc_in_t;

	typedef struct packed {
		logic               write_valid;
		logic [LEVEL_W-1:0] write_level;
		logic               accepted;
		logic [MODE_W-1:0]  mode_now;
	} bfc_out_t;

	typedef struct packed {
		logic take_item;
		logic load_out;
		logic load_pend;
		logic mul;
		logic div_step;
		logic div_finish;
		logic pend_to_out;
	} bfc_cmd_t;

	typedef struct packed {
		logic div_needed;
		logic div_last;
		logic slot_free;
	} bfc_status_t;

endpackage

/* hdl/bfc_ctrl.sv */
module bfc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bfc_pkg::bfc_status_t status,
	output bfc_pkg::bfc_cmd_t    cmd
);
	import bfc_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (status.div_needed) begin
						state_n = S_MUL;
					end else if (status.slot_free) begin
						cmd.load_out = 1'b1;
					end else begin
						cmd.load_pend = 1'b1;
						state_n       = S_EMIT;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_n = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					cmd.div_finish = 1'b1;
					state_n        = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.slot_free) begin
					cmd.pend_to_out = 1'b1;
					state_n         = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

/* hdl/bfc_datapath.sv */
module bfc_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bfc_pkg::bfc_in_t                   in_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  bfc_pkg::bfc_cmd_t                  cmd,
	output bfc_pkg::bfc_status_t               status,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bfc_pkg::bfc_out_t                  out_data
);
	import bfc_pkg::*;

	logic [TIME_W-1:0]  fade_q;
	logic [TIME_W-1:0]  step_int_q;
	logic [LEVEL_W-1:0] floor_q;

	logic [MODE_W-1:0]  mode_q;
	logic [LEVEL_W-1:0] saved_q;
	logic [LEVEL_W-1:0] driven_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [TIME_W-1:0]  step_q;

	logic [MODE_W-1:0]  mode_n;
	logic [LEVEL_W-1:0] saved_n;
	logic [LEVEL_W-1:0] driven_n;
	logic [TIME_W-1:0]  elapsed_n;
	logic [TIME_W-1:0]  step_n;
	logic [TIME_W-1:0]  el_inc;
	logic [TIME_W-1:0]  st_inc;
	logic               res_valid;
	logic [LEVEL_W-1:0] res_level;
	logic               res_acc;
	logic               div_needed;
	bfc_out_t           imm_res;

	logic [TIME_W-1:0]  rem_q;
	logic [PROD_W-1:0]  quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W:0]    trial;
	logic [TIME_W-1:0]  rem_n;
	logic               qbit;
	logic [PROD_W-1:0]  quo_n;
	logic [LEVEL_W-1:0] delta;
	logic [LEVEL_W-1:0] next_level;
	logic               level_changed;
	bfc_out_t           div_res;

	bfc_out_t           pend_q;
	bfc_out_t           out_q;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;

	// level update for items that complete at once
	always_comb begin
		el_inc     = (elapsed_q == '1) ? elapsed_q : elapsed_q + TIME_W'(1);
		st_inc     = (step_q == '1) ? step_q : step_q + TIME_W'(1);
		mode_n     = mode_q;
		saved_n    = saved_q;
		driven_n   = driven_q;
		elapsed_n  = elapsed_q;
		step_n     = step_q;
		res_valid  = 1'b0;
		res_level  = '0;
		res_acc    = 1'b0;
		div_needed = 1'b0;
		case (in_data.kind)
			KIND_TICK: begin
				if (mode_q == MODE_DIMMING) begin
					elapsed_n = el_inc;
					if (st_inc < step_int_q) begin
						step_n = st_inc;
					end else begin
						step_n = '0;
						if (el_inc >= fade_q) begin
							mode_n = MODE_DIMMED;
							if (driven_q > floor_q) begin
								driven_n  = floor_q;
								res_valid = 1'b1;
								res_level = floor_q;
							end
						end else begin
							div_needed = 1'b1;
						end
					end
				end
			end
			KIND_DIM: begin
				if (mode_q == MODE_IDLE) begin
					res_acc   = 1'b1;
					saved_n   = in_data.present_level;
					driven_n  = in_data.present_level;
					elapsed_n = '0;
					step_n    = '0;
					mode_n    = (in_data.present_level <= floor_q) ? MODE_DIMMED : MODE_DIMMING;
				end
			end
			KIND_RESTORE: begin
				if (mode_q == MODE_DIMMING || mode_q == MODE_DIMMED) begin
					res_valid = 1'b1;
					res_level = saved_q;
					driven_n  = saved_q;
					mode_n    = MODE_IDLE;
				end
			end
			default: ;
		endcase
		imm_res.write_valid = res_valid;
		imm_res.write_level = res_level;
		imm_res.accepted    = res_acc;
		imm_res.mode_now    = mode_n;
	end

	// restoring divider, one quotient bit per cycle
	assign delta = saved_q - floor_q;
	assign trial = {rem_q, quo_q[PROD_W-1]};

	always_comb begin
		if (trial >= {1'b0, fade_q}) begin
			rem_n = TIME_W'(trial - {1'b0, fade_q});
			qbit  = 1'b1;
		end else begin
			rem_n = trial[TIME_W-1:0];
			qbit  = 1'b0;
		end
		quo_n         = {quo_q[PROD_W-2:0], qbit};
		next_level    = saved_q - quo_n[LEVEL_W-1:0];
		level_changed = (next_level != driven_q);
		div_res.write_valid = level_changed;
		div_res.write_level = level_changed ? next_level : '0;
		div_res.accepted    = 1'b0;
		div_res.mode_now    = MODE_DIMMING;
	end

	assign status.div_needed = div_needed;
	assign status.div_last   = (cnt_q == CNT_W'(PROD_W - 1));
	assign status.slot_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q     <= FADE_TIME_RST;
			step_int_q <= STEP_INTERVAL_RST;
			floor_q    <= FLOOR_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FADE_TIME:     fade_q     <= cfg_data[TIME_W-1:0];
				REG_STEP_INTERVAL: step_int_q <= cfg_data[TIME_W-1:0];
				REG_FLOOR_LEVEL:   floor_q    <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			saved_q   <= '0;
			driven_q  <= '0;
			elapsed_q <= '0;
			step_q    <= '0;
		end else if (cmd.take_item) begin
			mode_q    <= mode_n;
			saved_q   <= saved_n;
			driven_q  <= driven_n;
			elapsed_q <= elapsed_n;
			step_q    <= step_n;
		end else if (cmd.div_finish && level_changed) begin
			driven_q  <= next_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q <= PROD_W'(elapsed_q) * PROD_W'(delta);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pend) begin
			pend_q <= imm_res;
		end else if (cmd.div_finish) begin
			pend_q <= div_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= imm_res;
		end else if (cmd.pend_to_out) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out || cmd.pend_to_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/backlight_fade_controller.sv */
// Backlight fade sequencer. A dim request taken in idle latches the present level and ramps it
// linearly down to floor_level over fade_time_ms ticks, recomputing every step_interval_ms
// ticks and writing only on change; a restore request writes the saved level back. Every
// input transaction gives exactly one result transaction. A tick that recomputes the level
// holds off the next input through the accepting cycle, the elapsed-times-span product, the
// restoring divider (one quotient bit per cycle, 32 quotient bits) and the hand-over of the
// result to the output register, which waits while the output stalls. The pending register
// lets the next input in while a result still waits in the output register. Configuration is
// always ready and takes effect at once; reset restores fade_time_ms 5000, step_interval_ms
// 100, floor_level 0 and idle mode.
module backlight_fade_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  bfc_pkg::bfc_in_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bfc_pkg::bfc_out_t                  out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bfc_pkg::*;

	bfc_cmd_t    cmd;
	bfc_status_t status;

	bfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bfc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
